@@ sv/pci_host_bridge_config_regs_unit_assert.svh @@
// Concurrent assertion macros, clocked on clk and disabled while arst_n is low.
`ifndef PCI_HOST_BRIDGE_CONFIG_REGS_UNIT_ASSERT_SVH
`define PCI_HOST_BRIDGE_CONFIG_REGS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define PHB_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define PHB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PHB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PHB_ASSERT(lbl, cond, msg)
`define PHB_ASSERT_IMPL(lbl, ante, cons, msg)
`define PHB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/phbcr_pkg.sv @@
package phbcr_pkg;

	localparam int unsigned REG_WORDS = 128;

	localparam int unsigned IDX_RESET = 16;
	localparam int unsigned IDX_CADDR = 67;
	localparam int unsigned IDX_CDATA = 68;

	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] SOFT_RESET_MASK = 32'h0000_000A;

	localparam logic FUNC_READ = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [4:0] DEV_BRIDGE = 5'd0;
	localparam logic [4:0] DEV_CTRL_A = 5'd1;
	localparam logic [4:0] DEV_CTRL_B = 5'd2;

	localparam logic [5:0] DW_ID = 6'd0;
	localparam logic [5:0] DW_CMD = 6'd1;
	localparam logic [5:0] DW_CLASS = 6'd2;
	localparam logic [5:0] DW_BIST = 6'd4;
	localparam logic [5:0] DW_SUBSYS = 6'd11;
	localparam logic [5:0] DW_INTR = 6'd15;

	localparam logic [31:0] BRIDGE_ID = 32'h0007_10EE;
	localparam logic [31:0] BRIDGE_CMD = 32'h0000_0006;
	localparam logic [31:0] BRIDGE_CLASS = 32'h0600_0001;
	localparam logic [31:0] BRIDGE_SUBSYS = 32'h0000_10EE;
	localparam logic [31:0] HDR_INTR = 32'h0000_0100;
	localparam logic [31:0] CTRL_ID = 32'h1562_04CC;
	localparam logic [31:0] CTRL_STATUS = 32'h02B0_0000;
	localparam logic [31:0] CTRL_A_CLASS = 32'h0C03_A001;
	localparam logic [31:0] CTRL_B_CLASS = 32'h0C03_2001;
	localparam logic [31:0] CTRL_B_BIST = 32'hA000_0000;

	typedef struct packed {
		logic enable;
		logic [6:0] rsvd_hi;
		logic [7:0] bus;
		logic [4:0] dev;
		logic [2:0] fn;
		logic [5:0] dword;
		logic [1:0] rsvd_lo;
	} caddr_t;

	function automatic logic cfg_hit(input caddr_t a);
		return a.enable && (a.bus == 8'd0) && (a.fn == 3'd0);
	endfunction

	function automatic logic [31:0] bridge_word(input logic [5:0] dw);
		logic [31:0] w;
		case (dw)
			DW_ID: w = BRIDGE_ID;
			DW_CMD: w = BRIDGE_CMD;
			DW_CLASS: w = BRIDGE_CLASS;
			DW_SUBSYS: w = BRIDGE_SUBSYS;
			DW_INTR: w = HDR_INTR;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] ctrl_word(input logic second, input logic [5:0] dw,
		input logic [15:0] cmd);
		logic [31:0] w;
		case (dw)
			DW_ID: w = CTRL_ID;
			DW_CMD: w = CTRL_STATUS | {16'd0, cmd};
			DW_CLASS: w = second ? CTRL_B_CLASS : CTRL_A_CLASS;
			DW_BIST: w = second ? CTRL_B_BIST : 32'd0;
			DW_SUBSYS: w = CTRL_ID;
			DW_INTR: w = HDR_INTR;
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] cfg_read(input caddr_t a, input logic [15:0] cmd_a,
		input logic [15:0] cmd_b);
		logic [31:0] w;
		if (!cfg_hit(a)) begin
			w = ALL_ONES;
		end else begin
			case (a.dev)
				DEV_BRIDGE: w = bridge_word(a.dword);
				DEV_CTRL_A: w = ctrl_word(1'b0, a.dword, cmd_a);
				DEV_CTRL_B: w = ctrl_word(1'b1, a.dword, cmd_b);
				default: w = ALL_ONES;
			endcase
		end
		return w;
	endfunction

endpackage

@@ sv/pci_host_bridge_config_regs_unit.sv @@
// Host bridge configuration register block. Each slave transfer is one 32-bit bus access
// (tuser: 0 read, 1 write) to a word of a 64 KiB window; each yields exactly one master
// transfer carrying the read data (zero for writes) and an out-of-range flag. Words below
// REG_WORDS form a read/write register file; word 67 holds the configuration address and
// word 68 runs a configuration cycle to the bridge header (device 0) or to the two
// controller headers (devices 1 and 2, with live command registers). Writing word 16 with
// bit 1 or 3 set clears the register file at once. One access is taken every clock unless
// a result waits on a stalled master side; its result appears in the cycle after acceptance,
// read through the registered read port of the register file memory, and holds while the master side stalls.
`include "pci_host_bridge_config_regs_unit_assert.svh"

module pci_host_bridge_config_regs_unit #(
	parameter int unsigned REG_WORDS = phbcr_pkg::REG_WORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // word_address[13:0], write_data[45:14], zero[47:46]
	input  logic [0:0]  s_tuser,  // func[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // read_data[31:0]
	output logic [0:0]  m_tuser   // out_of_range[0]
);

	localparam int unsigned IdxW = $clog2(REG_WORDS);
	localparam logic [IdxW-1:0] IdxReset = IdxW'(phbcr_pkg::IDX_RESET);
	localparam logic [IdxW-1:0] IdxCaddr = IdxW'(phbcr_pkg::IDX_CADDR);
	localparam logic [IdxW-1:0] IdxCdata = IdxW'(phbcr_pkg::IDX_CDATA);

	logic [31:0] mem [REG_WORDS];
	logic [REG_WORDS-1:0] ent_vld_q;
	phbcr_pkg::caddr_t caddr_q;
	logic [15:0] cmd_a_q;
	logic [15:0] cmd_b_q;

	logic vld_s1;
	logic sel_mem_s1;
	logic ent_vld_s1;
	logic oor_s1;
	logic [31:0] mem_rd_s1;
	logic [31:0] cfg_s1;

	logic [13:0] word_address;
	logic [31:0] write_data;
	logic func;
	logic [IdxW-1:0] idx;
	logic accept;
	logic in_range;
	logic is_wr;
	logic is_rd;
	logic soft_rst;
	logic store;
	logic cfg_wr;

	assign word_address = s_tdata[13:0];
	assign write_data = s_tdata[45:14];
	assign func = s_tuser[0];
	assign idx = word_address[IdxW-1:0];

	assign s_tready = !vld_s1 || m_tready;
	assign accept = s_tvalid && s_tready;
	assign in_range = {18'd0, word_address} < 32'(REG_WORDS);
	assign is_wr = accept && in_range && (func == phbcr_pkg::FUNC_WRITE);
	assign is_rd = accept && in_range && (func == phbcr_pkg::FUNC_READ);
	assign soft_rst = is_wr && (idx == IdxReset)
		&& ((write_data & phbcr_pkg::SOFT_RESET_MASK) != 32'd0);
	assign cfg_wr = is_wr && (idx == IdxCdata) && phbcr_pkg::cfg_hit(caddr_q)
		&& (caddr_q.dword == phbcr_pkg::DW_CMD);
	assign store = is_wr && (idx != IdxCdata) && !soft_rst;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[idx] <= write_data;
		end
		if (accept) begin
			mem_rd_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			caddr_q <= '0;
			cmd_a_q <= '0;
			cmd_b_q <= '0;
		end else begin
			if (soft_rst) begin
				ent_vld_q <= '0;
				caddr_q <= '0;
			end else if (store) begin
				ent_vld_q[idx] <= 1'b1;
				if (idx == IdxCaddr) begin
					caddr_q <= write_data;
				end
			end
			if (cfg_wr && (caddr_q.dev == phbcr_pkg::DEV_CTRL_A)) begin
				cmd_a_q <= write_data[15:0];
			end
			if (cfg_wr && (caddr_q.dev == phbcr_pkg::DEV_CTRL_B)) begin
				cmd_b_q <= write_data[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oor_s1 <= !in_range;
			sel_mem_s1 <= is_rd && (idx != IdxCdata);
			ent_vld_s1 <= ent_vld_q[idx];
			cfg_s1 <= (is_rd && (idx == IdxCdata))
				? phbcr_pkg::cfg_read(caddr_q, cmd_a_q, cmd_b_q) : 32'd0;
		end
	end

	assign m_tvalid = vld_s1;
	assign m_tdata = sel_mem_s1 ? (ent_vld_s1 ? mem_rd_s1 : 32'd0) : cfg_s1;
	assign m_tuser[0] = oor_s1;

	`PHB_ASSERT_IMPL(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0,
		"out-of-range result carries nonzero data")
	`PHB_ASSERT_IMPL(a_stall_only, !s_tready, m_tvalid && !m_tready,
		"slave side stalled without a stalled result")
	`PHB_ASSERT_NEXT(a_soft_rst, soft_rst, (ent_vld_q == '0) && (caddr_q == '0),
		"soft reset left register file contents")
	`PHB_ASSERT_NEXT(a_wr_zero, accept && (func == phbcr_pkg::FUNC_WRITE), m_tdata == 32'd0,
		"write result carries nonzero data")

endmodule

@@ tb/tb_pci_host_bridge_config_regs_unit.sv @@
module tb_pci_host_bridge_config_regs_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import phbcr_pkg::*;

	localparam int RANDOM_ACCESSES = 1800;
	localparam int TAIL_ACCESSES = 150;

	typedef struct packed {
		logic        func;
		logic [13:0] word_address;
		logic [31:0] write_data;
	} bus_access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        out_of_range;
	} bus_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	bus_access_t pending_accesses[$];
	bus_reply_t  predicted_replies[$];
	bus_access_t cur_access = '0;
	bus_reply_t  oldest_reply;
	logic        drive_valid;
	logic        quiet_tail = 1'b0;
	int          src_gap = 0;
	int          snk_gap = 0;
	int          mismatches = 0;
	int          reads_done = 0;
	int          writes_done = 0;
	int          cfg_cycles = 0;
	int          oor_accesses = 0;
	int          file_clears = 0;

	logic [31:0] regfile_model [REG_WORDS] = '{default: '0};
	logic [15:0] cmd_a_model = '0;
	logic [15:0] cmd_b_model = '0;

	pci_host_bridge_config_regs_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic bus_reply_t compute_access(input bus_access_t a);
		bus_reply_t r;
		caddr_t     ca;
		logic       hit;
		r = '0;
		ca = caddr_t'(regfile_model[IDX_CADDR]);
		hit = ca.enable && (ca.bus == 8'd0) && (ca.fn == 3'd0);
		if (a.word_address >= REG_WORDS) begin
			r.out_of_range = 1'b1;
		end else if (a.func == FUNC_READ) begin
			if (a.word_address != IDX_CDATA) begin
				r.read_data = regfile_model[a.word_address];
			end else if (!hit) begin
				r.read_data = ALL_ONES;
			end else begin
				case (ca.dev)
					DEV_BRIDGE: begin
						case (ca.dword)
							DW_ID: r.read_data = BRIDGE_ID;
							DW_CMD: r.read_data = BRIDGE_CMD;
							DW_CLASS: r.read_data = BRIDGE_CLASS;
							DW_SUBSYS: r.read_data = BRIDGE_SUBSYS;
							DW_INTR: r.read_data = HDR_INTR;
							default: r.read_data = '0;
						endcase
					end
					DEV_CTRL_A, DEV_CTRL_B: begin
						case (ca.dword)
							DW_ID, DW_SUBSYS: r.read_data = CTRL_ID;
							DW_CMD: r.read_data = CTRL_STATUS | {16'd0,
								(ca.dev == DEV_CTRL_B) ? cmd_b_model : cmd_a_model};
							DW_CLASS: r.read_data = (ca.dev == DEV_CTRL_B) ?
								CTRL_B_CLASS : CTRL_A_CLASS;
							DW_BIST: r.read_data = (ca.dev == DEV_CTRL_B) ? CTRL_B_BIST : '0;
							DW_INTR: r.read_data = HDR_INTR;
							default: r.read_data = '0;
						endcase
					end
					default: r.read_data = ALL_ONES;
				endcase
			end
		end else if (a.word_address == IDX_CDATA) begin
			if (hit && ca.dword == DW_CMD) begin
				if (ca.dev == DEV_CTRL_A) begin
					cmd_a_model = a.write_data[15:0];
				end else if (ca.dev == DEV_CTRL_B) begin
					cmd_b_model = a.write_data[15:0];
				end
			end
		end else if (a.word_address == IDX_RESET && (a.write_data & SOFT_RESET_MASK) != '0) begin
			regfile_model = '{default: '0};
		end else begin
			regfile_model[a.word_address] = a.write_data;
		end
		return r;
	endfunction

	function automatic logic [31:0] caddr_for(input logic en, input logic [7:0] bus,
		input logic [4:0] dev, input logic [2:0] fn, input logic [5:0] dw);
		caddr_t c;
		c = '0;
		c.enable = en;
		c.bus = bus;
		c.dev = dev;
		c.fn = fn;
		c.dword = dw;
		return c;
	endfunction

	task automatic queue_access(input logic func, input int addr, input logic [31:0] data);
		bus_access_t a;
		a.func = func;
		a.word_address = addr[13:0];
		a.write_data = data;
		pending_accesses.push_back(a);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			quiet_tail <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_replies.push_back(compute_access(cur_access));
				if (cur_access.word_address >= REG_WORDS) begin
					oor_accesses++;
				end else if (cur_access.word_address == IDX_CDATA) begin
					cfg_cycles++;
				end else if (cur_access.func == FUNC_WRITE &&
					cur_access.word_address == IDX_RESET &&
					(cur_access.write_data & SOFT_RESET_MASK) != '0) begin
					file_clears++;
				end
				if (cur_access.func == FUNC_WRITE) begin
					writes_done++;
				end else begin
					reads_done++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					drive_valid = 1'b0;
				end else if (pending_accesses.size() == 0) begin
					drive_valid = 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
					src_gap = $urandom_range(0, 8);
					drive_valid = 1'b0;
				end else begin
					cur_access = pending_accesses.pop_front();
					drive_valid = 1'b1;
				end
				s_tvalid <= drive_valid;
				s_tdata <= {2'b00, cur_access.write_data, cur_access.word_address};
				s_tuser <= cur_access.func;
			end
			quiet_tail <= pending_accesses.size() < TAIL_ACCESSES;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected reply data %h oor %b", m_tdata, m_tuser));
				end else begin
					oldest_reply = predicted_replies.pop_front();
					if (m_tdata !== oldest_reply.read_data) begin
						report_mismatch($sformatf("read_data %h, expected %h",
							m_tdata, oldest_reply.read_data));
					end
					if (m_tuser[0] !== oldest_reply.out_of_range) begin
						report_mismatch($sformatf("out_of_range %b, expected %b",
							m_tuser[0], oldest_reply.out_of_range));
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				snk_gap = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int          kind;
		int          n;
		int          addr;
		int          total;
		logic        func;
		logic        en;
		logic [7:0]  bus;
		logic [4:0]  dev;
		logic [2:0]  fn;
		logic [5:0]  dw;
		logic [31:0] data;
		logic [31:0] caddr;
		logic [5:0]  hdr_dwords [6];

		hdr_dwords = '{DW_ID, DW_CMD, DW_CLASS, DW_BIST, DW_SUBSYS, DW_INTR};

		queue_access(FUNC_READ, 0, '0);
		queue_access(FUNC_WRITE, 0, 32'hFFFF_FFFF);
		queue_access(FUNC_READ, 0, '0);
		queue_access(FUNC_WRITE, REG_WORDS - 1, 32'hA5A5_A5A5);
		queue_access(FUNC_READ, REG_WORDS - 1, 32'hFFFF_FFFF);
		queue_access(FUNC_WRITE, REG_WORDS, 32'hDEAD_BEEF);
		queue_access(FUNC_READ, REG_WORDS, '0);
		queue_access(FUNC_WRITE, 16383, 32'hFFFF_FFFF);
		queue_access(FUNC_READ, 16383, '0);
		queue_access(FUNC_READ, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_CADDR, caddr_for(1'b1, 8'd0, DEV_CTRL_A, 3'd0, DW_CMD));
		queue_access(FUNC_WRITE, IDX_CDATA, 32'hFFFF_FFFF);
		queue_access(FUNC_READ, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_CADDR, caddr_for(1'b1, 8'd0, DEV_CTRL_B, 3'd0, DW_BIST));
		queue_access(FUNC_READ, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_CADDR, caddr_for(1'b1, 8'd0, DEV_BRIDGE, 3'd0, DW_CLASS));
		queue_access(FUNC_READ, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_CADDR, caddr_for(1'b1, 8'd0, 5'd31, 3'd0, DW_ID));
		queue_access(FUNC_READ, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_CADDR, caddr_for(1'b1, 8'hFF, DEV_CTRL_A, 3'd7, DW_CMD));
		queue_access(FUNC_WRITE, IDX_CDATA, '0);
		queue_access(FUNC_WRITE, IDX_RESET, 32'h0000_0005);
		queue_access(FUNC_READ, IDX_RESET, '0);
		queue_access(FUNC_WRITE, IDX_RESET, 32'h0000_0002);
		queue_access(FUNC_READ, IDX_CADDR, '0);
		queue_access(FUNC_WRITE, IDX_RESET, 32'h0000_0008);
		queue_access(FUNC_READ, REG_WORDS - 1, '0);

		total = pending_accesses.size() + RANDOM_ACCESSES;
		while (pending_accesses.size() < total) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				en = $urandom_range(0, 9) != 0;
				bus = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0;
				fn = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'd0;
				n = $urandom_range(0, 9);
				dev = (n < 3) ? DEV_BRIDGE : (n < 6) ? DEV_CTRL_A : (n < 9) ? DEV_CTRL_B :
					5'($urandom);
				dw = ($urandom_range(0, 3) == 0) ? 6'($urandom) :
					hdr_dwords[$urandom_range(0, 5)];
				caddr = caddr_for(en, bus, dev, fn, dw);
				caddr[30:24] = 7'($urandom);
				caddr[1:0] = 2'($urandom);
				queue_access(FUNC_WRITE, IDX_CADDR, caddr);
				n = $urandom_range(1, 4);
				repeat (n) begin
					queue_access(1'($urandom), IDX_CDATA, $urandom);
				end
			end else if (kind < 82) begin
				addr = $urandom_range(0, REG_WORDS - 1);
				func = 1'($urandom);
				data = $urandom;
				if (addr == IDX_RESET) begin
					data = data & ~SOFT_RESET_MASK;
				end
				queue_access(func, addr, data);
			end else if (kind < 94) begin
				queue_access(1'($urandom), $urandom_range(REG_WORDS, 16383), $urandom);
			end else if (kind < 96) begin
				data = $urandom;
				data[$urandom_range(0, 1) ? 1 : 3] = 1'b1;
				queue_access(FUNC_WRITE, IDX_RESET, data);
			end else begin
				queue_access(FUNC_READ, $urandom_range(0, 1) ? IDX_CADDR : IDX_RESET, $urandom);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_accesses.size() != 0 || s_tvalid || predicted_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (predicted_replies.size() != 0) begin
			report_mismatch($sformatf("%0d replies never arrived", predicted_replies.size()));
		end

		$display("Ran %0d reads and %0d writes, %0d of them on the config data port.",
			reads_done, writes_done, cfg_cycles);
		$display("%0d accesses beyond the register file, %0d soft clears, %0d mismatches.",
			oor_accesses, file_clears, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/phbcr_pkg.sv
sv/pci_host_bridge_config_regs_unit.sv
tb/tb_pci_host_bridge_config_regs_unit.sv
